// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the route update RTL. Every check is sampled on
// the rising clock edge and is switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DVRU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// An implication: whenever the antecedent holds, the consequent holds too.
`define DVRU_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- src/dvru_pkg.sv -----
// ----------------------------------------------------------------------------
// Distance-vector route update package
// Shared types and codes: register indexes, word kinds, result actions,
// sequencer states and the stored route entry.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

   // Width of every network address handled by the block.
   localparam int ADDR_W = 32;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDR_0      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDR_ENABLE = 3'd4;

   // Request word kinds.
   localparam logic FUNC_ADVERTISE = 1'b0;
   localparam logic FUNC_INSTALL   = 1'b1;

   // Width of the advertised cost field and of the response fields.
   localparam int ADV_COST_W = 5;
   localparam int ACTION_W   = 3;
   localparam int RSP_INDEX_W = 6;
   localparam int RSP_COST_W = 5;

   // Outcome reported with every response word.
   typedef enum logic [ACTION_W-1:0] {
      ACT_IGNORED   = 3'd0,
      ACT_REPLACED  = 3'd1,
      ACT_KEPT      = 3'd2,
      ACT_ADDED     = 3'd3,
      ACT_DROPPED   = 3'd4,
      ACT_INSTALLED = 3'd5
   } action_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOP,
      ST_DONE
   } state_type;

   // Address part of one routing table entry.
   typedef struct packed {
      logic [ADDR_W-1:0] dest;
      logic [ADDR_W-1:0] next_hop;
      logic [ADDR_W-1:0] iface;
   } route_entry_type;

endpackage

`default_nettype wire

// ----- src/dvru_table.sv -----
// ----------------------------------------------------------------------------
// Route table memory
// Single write port and single registered read port holding the address
// fields and the hop cost of every route.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_table
   import dvru_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int COST_W = 5,
   parameter int IDX_W  = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [IDX_W-1:0]     wr_addr,
   input  wire route_entry_type      wr_entry,
   input  wire logic [COST_W-1:0]    wr_cost,
   input  wire logic                 rd_en,
   input  wire logic [IDX_W-1:0]     rd_addr,
   output route_entry_type           rd_entry,
   output logic      [COST_W-1:0]    rd_cost
);

   route_entry_type     route_mem_ff [DEPTH];
   logic [COST_W-1:0]   cost_mem_ff  [DEPTH];
   route_entry_type     rd_entry_ff;
   logic [COST_W-1:0]   rd_cost_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem_ff[wr_addr] <= wr_entry;
         cost_mem_ff[wr_addr]  <= wr_cost;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= route_mem_ff[rd_addr];
         rd_cost_ff  <= cost_mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_cost  = rd_cost_ff;

endmodule

`default_nettype wire

// ----- src/dvru_own_match.sv -----
// ----------------------------------------------------------------------------
// Local address match
// Flags a destination that equals one of the enabled local interface
// addresses of this node.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_own_match
   import dvru_pkg::*;
#(
   parameter int NUM_ADDRS = 4
) (
   input  wire logic [ADDR_W-1:0]    own_addr [NUM_ADDRS],
   input  wire logic [NUM_ADDRS-1:0] own_enable,
   input  wire logic [ADDR_W-1:0]    addr,
   output logic                      hit
);

   logic [NUM_ADDRS-1:0] match;

   // One comparator per local address, qualified by its enable bit.
   always_comb begin
      for (int i = 0; i < NUM_ADDRS; i++) begin
         match[i] = own_enable[i] && (own_addr[i] == addr);
      end
   end

   assign hit = |match;

endmodule

`default_nettype wire

// ----- src/distance_vector_route_update.sv -----
// ----------------------------------------------------------------------------
// Distance-vector route update
// Keeps a routing table and applies one advertised or locally installed
// route per request word, answering with one response word.
// ----------------------------------------------------------------------------
// One request word is worked on at a time and req_ready is low meanwhile. An
// advertised word whose destination is an enabled local address skips the
// scan and is ignored. Otherwise the table is walked entry by entry through
// its single read port, one entry per cycle, and one shared 32-bit comparator
// checks first the destination and then, on a hit, the stored next hop. The
// response sits in an output register, so the next word is taken while it
// waits. The table needs no clearing after reset; only entries below the
// route count are ever read.
`default_nettype none
`include "assert_macros.svh"

module distance_vector_route_update
   import dvru_pkg::*;
#(
   parameter int TABLE_DEPTH   = 64,
   parameter int MAX_HOPS      = 16,
   parameter int NUM_OWN_ADDRS = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_func,
   input  wire logic [ADDR_W-1:0]       req_adv_dest,
   input  wire logic [ADV_COST_W-1:0]   req_adv_cost,
   input  wire logic [ADDR_W-1:0]       req_neighbor_addr,
   input  wire logic [ADDR_W-1:0]       req_recv_iface_addr,

   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [ACTION_W-1:0]          rsp_action,
   output logic [RSP_INDEX_W-1:0]       rsp_entry_index,
   output logic [RSP_COST_W-1:0]        rsp_route_cost,

   input  wire logic                    csr_we,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int COST_W = $clog2(MAX_HOPS + 1);

   // Configuration registers.
   logic [ADDR_W-1:0]        own_addr_ff [NUM_OWN_ADDRS];
   logic [ADDR_W-1:0]        own_addr_in [NUM_OWN_ADDRS];
   logic [NUM_OWN_ADDRS-1:0] own_enable_ff, own_enable_in;

   // Sequencer and scan control.
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;

   // Word being worked on.
   logic                func_ff, func_in;
   logic [ADDR_W-1:0]   dest_ff, dest_in;
   logic [ADDR_W-1:0]   neighbor_ff, neighbor_in;
   logic [ADDR_W-1:0]   recv_ff, recv_in;
   logic [COST_W-1:0]   cost_ff, cost_in;

   // Finished result and output register.
   action_type          res_action_ff, res_action_in;
   logic [IDX_W-1:0]    res_index_ff, res_index_in;
   logic [COST_W-1:0]   res_cost_ff, res_cost_in;
   logic                rsp_valid_ff, rsp_valid_in;
   action_type          rsp_action_ff, rsp_action_in;
   logic [RSP_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [RSP_COST_W-1:0]  rsp_cost_ff, rsp_cost_in;

   // Datapath.
   logic                req_fire;
   logic                own_hit;
   logic [ADV_COST_W:0] cost_sum;
   logic [COST_W-1:0]   cost_calc;
   logic [ADDR_W-1:0]   cmp_a, cmp_b;
   logic                cmp_eq;
   logic                scan_hit, scan_end, table_full, replace, rsp_load;
   logic                rd_en, tbl_we;
   logic [IDX_W-1:0]    tbl_wr_addr;
   route_entry_type     tbl_wr_entry, rd_entry;
   logic [COST_W-1:0]   rd_cost;

   // Route table storage.
   dvru_table #(
      .DEPTH  (TABLE_DEPTH),
      .COST_W (COST_W),
      .IDX_W  (IDX_W)
   ) u_table (
      .clock    (clock),
      .wr_en    (tbl_we),
      .wr_addr  (tbl_wr_addr),
      .wr_entry (tbl_wr_entry),
      .wr_cost  (cost_ff),
      .rd_en    (rd_en),
      .rd_addr  (scan_ff[IDX_W-1:0]),
      .rd_entry (rd_entry),
      .rd_cost  (rd_cost)
   );

   // Local address check on the incoming word.
   dvru_own_match #(
      .NUM_ADDRS (NUM_OWN_ADDRS)
   ) u_own_match (
      .own_addr   (own_addr_ff),
      .own_enable (own_enable_ff),
      .addr       (req_adv_dest),
      .hit        (own_hit)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Advertised cost plus one hop, local installs at the given cost,
   // saturated at the unreachable cost.
   assign cost_sum  = {1'b0, req_adv_cost} + {{ADV_COST_W{1'b0}}, ~req_func};
   assign cost_calc = (9'(cost_sum) > 9'(MAX_HOPS)) ? COST_W'(MAX_HOPS) : COST_W'(cost_sum);

   // Shared comparator: destination during the scan, next hop afterwards.
   assign cmp_a  = (state_ff == ST_HOP) ? neighbor_ff : dest_ff;
   assign cmp_b  = (state_ff == ST_HOP) ? rd_entry.next_hop : rd_entry.dest;
   assign cmp_eq = (cmp_a == cmp_b);

   // Scan status. A read is held back once a hit is seen so that the
   // matching entry stays in the read register.
   assign scan_hit   = (state_ff == ST_SCAN) && cmp_valid_ff && cmp_eq;
   assign scan_end   = (state_ff == ST_SCAN) && !scan_hit && (scan_ff == count_ff);
   assign rd_en      = (state_ff == ST_SCAN) && !scan_hit && (scan_ff != count_ff);
   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign replace    = func_ff || (cost_ff < rd_cost) || cmp_eq;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign tbl_wr_entry.dest     = dest_ff;
   assign tbl_wr_entry.next_hop = neighbor_ff;
   assign tbl_wr_entry.iface    = recv_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_func == FUNC_ADVERTISE) && own_hit) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_HOP;
            end else if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_HOP: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control and result selection.
   always_comb begin
      count_in      = count_ff;
      scan_in       = scan_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      func_in       = func_ff;
      dest_in       = dest_ff;
      neighbor_in   = neighbor_ff;
      recv_in       = recv_ff;
      cost_in       = cost_ff;
      res_action_in = res_action_ff;
      res_index_in  = res_index_ff;
      res_cost_in   = res_cost_ff;
      tbl_we        = 1'b0;
      tbl_wr_addr   = cmp_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in       = req_func;
               dest_in       = req_adv_dest;
               neighbor_in   = req_neighbor_addr;
               recv_in       = req_recv_iface_addr;
               cost_in       = cost_calc;
               scan_in       = '0;
               res_action_in = ACT_IGNORED;
               res_index_in  = '0;
               res_cost_in   = cost_calc;
            end
         end
         ST_SCAN: begin
            cmp_valid_in = rd_en;
            // The compare index follows the entry in the read register.
            if (rd_en) begin
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + 1'b1;
            end
            if (scan_end) begin
               if (table_full) begin
                  res_action_in = ACT_DROPPED;
                  res_index_in  = '0;
                  res_cost_in   = cost_ff;
               end else begin
                  tbl_we        = 1'b1;
                  tbl_wr_addr   = count_ff[IDX_W-1:0];
                  res_action_in = (func_ff == FUNC_INSTALL) ? ACT_INSTALLED : ACT_ADDED;
                  res_index_in  = count_ff[IDX_W-1:0];
                  res_cost_in   = cost_ff;
                  count_in      = count_ff + 1'b1;
               end
            end
         end
         ST_HOP: begin
            res_index_in = cmp_idx_ff;
            if (replace) begin
               tbl_we        = 1'b1;
               res_action_in = (func_ff == FUNC_INSTALL) ? ACT_INSTALLED : ACT_REPLACED;
               res_cost_in   = cost_ff;
            end else begin
               res_action_in = ACT_KEPT;
               res_cost_in   = rd_cost;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Output register: loaded from the finished result, freed when taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_action_in = rsp_action_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_cost_in   = rsp_cost_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = res_action_ff;
         rsp_index_in  = RSP_INDEX_W'(res_index_ff);
         rsp_cost_in   = RSP_COST_W'(res_cost_ff);
      end
   end

   // Configuration writes; indexes past the register list are ignored.
   always_comb begin
      own_addr_in   = own_addr_ff;
      own_enable_in = own_enable_ff;
      if (csr_we) begin
         for (int i = 0; i < NUM_OWN_ADDRS; i++) begin
            if (csr_index == (CSR_OWN_ADDR_0 + CSR_INDEX_W'(i))) begin
               own_addr_in[i] = csr_wdata[ADDR_W-1:0];
            end
         end
         if (csr_index == CSR_OWN_ADDR_ENABLE) begin
            own_enable_in = csr_wdata[NUM_OWN_ADDRS-1:0];
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         own_enable_ff <= '0;
         for (int i = 0; i < NUM_OWN_ADDRS; i++) begin
            own_addr_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         own_enable_ff <= own_enable_in;
         own_addr_ff   <= own_addr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      func_ff       <= func_in;
      dest_ff       <= dest_in;
      neighbor_ff   <= neighbor_in;
      recv_ff       <= recv_in;
      cost_ff       <= cost_in;
      res_action_ff <= res_action_in;
      res_index_ff  <= res_index_in;
      res_cost_ff   <= res_cost_in;
      rsp_action_ff <= rsp_action_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_cost_ff   <= rsp_cost_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_route_cost  = rsp_cost_ff;

   // The route count never passes the table depth.
   `DVRU_ASSERT(a_count_range, count_ff <= CNT_W'(TABLE_DEPTH), "route count above table depth")
   // The table is written only when a scan ends or a hit is settled.
   `DVRU_ASSERT_IMPL(a_write_state, tbl_we, (state_ff == ST_SCAN) || (state_ff == ST_HOP), "table written outside scan")
   // The next-hop check always follows a destination hit in the scan.
   `DVRU_ASSERT_IMPL(a_hop_after_scan, state_ff == ST_HOP, $past(state_ff) == ST_SCAN, "next hop check without scan hit")
   // Only entries below the route count are ever read.
   `DVRU_ASSERT_IMPL(a_read_in_table, rd_en, scan_ff < count_ff, "read beyond stored routes")

endmodule

`default_nettype wire
